>>> rtl/core/sector_cache_clock_replacement_assert.svh
// assertion macros for the sector cache tag controller
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS
// concurrent assertion on an explicit clock and active-low reset
`define SCCR_ASSERT_CLK(lbl, clk_i, rst_n_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) \
		else $error("sector cache assertion failed");
// concurrent assertion on the block clock and reset
`define SCCR_ASSERT(lbl, prop) `SCCR_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define SCCR_ASSERT_CLK(lbl, clk_i, rst_n_i, prop)
`define SCCR_ASSERT(lbl, prop)
`endif

`endif

>>> rtl/core/sccr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sccr_pkg;

	// cache geometry
	localparam int SLOTS    = 64;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);

	// field widths
	localparam int SECTOR_W   = 32;
	localparam int SLOT_W     = 6;
	localparam int OP_W       = 2;
	localparam int OUT_USED_W = SLOT_W + 3 + SECTOR_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	// request kinds
	typedef enum logic [OP_W-1:0] {
		OP_READ       = 2'd0,
		OP_WRITE      = 2'd1,
		OP_READ_AHEAD = 2'd2,
		OP_FLUSH      = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SWEEP,
		ST_VICT,
		ST_APPLY,
		ST_FL_SCAN,
		ST_FL_READ,
		ST_FL_END
	} state_t;

	// slot index plus one, wrapping at the slot count
	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sccr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sccr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/sector_cache_clock_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sector_cache_clock_replacement_assert.svh"

// channel   dir  signals                    contents
// s_axis    in   tdata[31:0], tuser[1:0]    request: sector, op
// m_axis    out  tdata[47:0], tlast         result: slot, hit, fill, writeback, sector
//
// read, write and read-ahead walk the tag memory one slot a cycle until a hit or the last slot;
// a hit in slot i ends the walk at slot i
// a miss with no free slot adds a clock sweep of the hand and one tag read
// flush scans every slot and reads back each dirty one, one tag memory port throughout
// reset clears the valid, dirty and accessed marks at once; no clearing pass
// a request is taken only while idle; a stalled result holds the sequencer

module sector_cache_clock_replacement (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [sccr_pkg::SECTOR_W-1:0]  s_axis_tdata,  // sector
	input  logic [sccr_pkg::OP_W-1:0]      s_axis_tuser,  // op
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// slot, hit, fill_needed, writeback_needed, writeback_sector, zero pad
	output logic [sccr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);

	import sccr_pkg::*;

	state_t                state_q, state_d;
	op_t                   op_q;
	logic [SECTOR_W-1:0]   sector_q;
	logic [SLOTS-1:0]      valid_q, dirty_q, acc_q;
	logic [IDX_W-1:0]      hand_q, slot_q, free_slot_q, pidx_s1;
	logic                  free_found_q, pend_s1, hit_q, wb_q, have_prev_q;
	logic [CNT_W-1:0]      scan_q;
	logic [SECTOR_W-1:0]   wbsec_q;
	logic                  out_valid_q, out_last_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                  s_accept, out_free, scan_more, issue, match, scan_end;
	logic [IDX_W-1:0]      scan_idx;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_raddr;
	logic [SECTOR_W-1:0]   ram_rdata;
	logic                  emit, emit_hit, emit_fill, emit_wb, emit_last;
	logic                  flushing;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign scan_idx      = scan_q[IDX_W-1:0];
	assign scan_more     = (scan_q < CNT_W'(SLOTS));
	assign issue         = (state_q == ST_LOOK) && scan_more;
	assign match         = pend_s1 && valid_q[pidx_s1] && (ram_rdata == sector_q);
	assign scan_end      = pend_s1 && (pidx_s1 == IDX_W'(SLOTS - 1));
	assign flushing      = (state_q == ST_FL_SCAN) || (state_q == ST_FL_READ) ||
		(state_q == ST_FL_END);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// tag memory
	sccr_ram #(
		.WIDTH(SECTOR_W),
		.DEPTH(SLOTS)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(sector_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, result strobe and memory control
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_hit  = 1'b0;
		emit_fill = 1'b0;
		emit_wb   = 1'b0;
		emit_last = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = scan_idx;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					state_d = (op_t'(s_axis_tuser) == OP_FLUSH) ? ST_FL_SCAN : ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (match) begin
					state_d = ST_APPLY;
				end else if (scan_end) begin
					state_d = free_found_q ? ST_APPLY : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				ram_raddr = hand_q;
				if (!acc_q[hand_q]) begin
					state_d = ST_VICT;
				end
			end
			ST_VICT: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_hit  = hit_q;
					emit_fill = !hit_q;
					emit_wb   = wb_q;
					emit_last = 1'b1;
					ram_we    = !hit_q;
					state_d   = ST_IDLE;
				end
			end
			ST_FL_SCAN: begin
				if (!scan_more) begin
					state_d = ST_FL_END;
				end else if (valid_q[scan_idx] && dirty_q[scan_idx]) begin
					state_d = ST_FL_READ;
				end
			end
			ST_FL_READ: begin
				if (!have_prev_q || out_free) begin
					emit    = have_prev_q;
					emit_wb = 1'b1;
					state_d = ST_FL_SCAN;
				end
			end
			ST_FL_END: begin
				if (!have_prev_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_wb   = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state: marks, hand, scan counter, result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			dirty_q      <= '0;
			acc_q        <= '0;
			hand_q       <= '0;
			scan_q       <= '0;
			pend_s1      <= 1'b0;
			free_found_q <= 1'b0;
			have_prev_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			pend_s1 <= issue && (state_d == ST_LOOK);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						scan_q       <= '0;
						free_found_q <= 1'b0;
						have_prev_q  <= 1'b0;
					end
				end
				ST_LOOK: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
						if (!valid_q[scan_idx]) begin
							free_found_q <= 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					// second chance: clear accessed and move on, else evict
					if (acc_q[hand_q]) begin
						acc_q[hand_q] <= 1'b0;
					end else begin
						valid_q[hand_q] <= 1'b0;
					end
					hand_q <= slot_inc(hand_q);
				end
				ST_APPLY: begin
					// a fill starts with clear marks, then the request's own marks
					if (out_free) begin
						valid_q[slot_q] <= 1'b1;
						acc_q[slot_q]   <= (op_q == OP_READ) || (op_q == OP_WRITE) ||
							(hit_q && acc_q[slot_q]);
						dirty_q[slot_q] <= (op_q == OP_WRITE) || (hit_q && dirty_q[slot_q]);
					end
				end
				ST_FL_SCAN: begin
					if (scan_more && !(valid_q[scan_idx] && dirty_q[scan_idx])) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_FL_READ: begin
					if (!have_prev_q || out_free) begin
						have_prev_q <= 1'b1;
						scan_q      <= scan_q + 1'b1;
					end
				end
				ST_FL_END: begin
					if (state_d == ST_IDLE) begin
						have_prev_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		pidx_s1 <= scan_idx;
		if (emit) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, wbsec_q, emit_wb, emit_fill, emit_hit,
				SLOT_W'(slot_q)};
			out_last_q <= emit_last;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					op_q     <= op_t'(s_axis_tuser);
					sector_q <= s_axis_tdata;
					hit_q    <= 1'b0;
					wb_q     <= 1'b0;
					wbsec_q  <= '0;
				end
			end
			ST_LOOK: begin
				// lowest free slot, recorded as the scan passes it
				if (issue && !valid_q[scan_idx] && !free_found_q) begin
					free_slot_q <= scan_idx;
				end
				if (match) begin
					slot_q <= pidx_s1;
					hit_q  <= 1'b1;
				end else if (scan_end && free_found_q) begin
					slot_q <= free_slot_q;
				end
			end
			ST_SWEEP: begin
				if (!acc_q[hand_q]) begin
					slot_q <= hand_q;
					wb_q   <= valid_q[hand_q] && dirty_q[hand_q];
				end
			end
			ST_VICT: begin
				if (wb_q) begin
					wbsec_q <= ram_rdata;
				end
			end
			ST_FL_READ: begin
				if (!have_prev_q || out_free) begin
					slot_q  <= scan_idx;
					wbsec_q <= ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	`SCCR_ASSERT(a_hand_in_range, CNT_W'(hand_q) < CNT_W'(SLOTS))
	`SCCR_ASSERT(a_apply_leaves_valid, (state_q == ST_APPLY) && out_free |=> valid_q[slot_q])
	`SCCR_ASSERT(a_flush_keeps_marks, flushing |=> $stable(dirty_q) && $stable(valid_q))
	`SCCR_ASSERT(a_idle_drained, s_axis_tready |-> !pend_s1 && !have_prev_q)

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sccr_pkg::*;

	localparam int LIMIT    = 800000;
	localparam int QUIET_LO = 8000;
	localparam int QUIET_HI = 14000;
	localparam int HOLD_AT  = 60;
	localparam int HOLD_LEN = 600;
	localparam int POOL     = 96;
	localparam int N_RANDOM = 210;
	localparam int TAIL     = 2 * SLOTS + 64;

	// one request and one cache answer
	typedef struct packed {
		op_t                 op;
		logic [SECTOR_W-1:0] sector;
	} sector_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic                hit;
		logic                fill;
		logic                wb;
		logic [SECTOR_W-1:0] wb_sector;
		logic                last;
	} cache_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SECTOR_W-1:0] s_axis_tdata = '0;  // sector
	logic [OP_W-1:0] s_axis_tuser = OP_READ; // op
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// slot, hit, fill_needed, writeback_needed, writeback_sector, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	sector_req_t   req_queue[$];
	cache_answer_t answer_queue[$];
	sector_req_t   next_req;
	logic [SECTOR_W-1:0] sector_pool[POOL];

	// shadow copy of the tag controller
	logic [SECTOR_W-1:0] tag_copy[SLOTS];
	bit valid_copy[SLOTS];
	bit dirty_copy[SLOTS];
	bit accessed_copy[SLOTS];
	int hand_copy;

	int cycle = 0;
	int sent_cnt = 0;
	int rx_cnt = 0;
	int err_cnt = 0;
	int hit_cnt = 0;
	int evict_cnt = 0;
	int evict_wb_cnt = 0;
	int flush_cnt = 0;
	int flush_wb_cnt = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	wire quiet = (cycle >= QUIET_LO) && (cycle < QUIET_HI);

	sector_cache_clock_replacement dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cycle count and run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle,
				answer_queue.size());
			$display("FAILURE");
			$finish;
		end
	end

	// work out the answers one request causes and update the shadow state
	function automatic void predict_lookup(input op_t op, input logic [SECTOR_W-1:0] sector);
		cache_answer_t a;
		int pick;
		int h;
		int n_dirty;
		int seen;
		bit found;
		a = '0;
		if (op == OP_FLUSH) begin
			n_dirty = 0;
			seen = 0;
			flush_cnt++;
			for (int i = 0; i < SLOTS; i++)
				if (valid_copy[i] && dirty_copy[i])
					n_dirty++;
			for (int i = 0; i < SLOTS; i++) begin
				if (valid_copy[i] && dirty_copy[i]) begin
					a.slot = SLOT_W'(i);
					a.wb = 1'b1;
					a.wb_sector = tag_copy[i];
					seen++;
					a.last = (seen == n_dirty);
					answer_queue.push_back(a);
					flush_wb_cnt++;
				end
			end
		end else begin
			found = 1'b0;
			pick = 0;
			for (int i = 0; i < SLOTS && !found; i++) begin
				if (valid_copy[i] && tag_copy[i] == sector) begin
					pick = i;
					found = 1'b1;
				end
			end
			if (found) begin
				a.hit = 1'b1;
				hit_cnt++;
			end else begin
				// lowest free slot first
				for (int i = 0; i < SLOTS && !found; i++) begin
					if (!valid_copy[i]) begin
						pick = i;
						found = 1'b1;
					end
				end
				// second chance sweep when the cache is full
				if (!found) begin
					h = hand_copy % SLOTS;
					for (int n = 0; n <= SLOTS && accessed_copy[h]; n++) begin
						accessed_copy[h] = 1'b0;
						h = (h + 1) % SLOTS;
					end
					if (valid_copy[h] && dirty_copy[h]) begin
						a.wb = 1'b1;
						a.wb_sector = tag_copy[h];
						evict_wb_cnt++;
					end
					hand_copy = (h + 1) % SLOTS;
					pick = h;
					evict_cnt++;
				end
				tag_copy[pick] = sector;
				valid_copy[pick] = 1'b1;
				dirty_copy[pick] = 1'b0;
				accessed_copy[pick] = 1'b0;
				a.fill = 1'b1;
			end
			if (op == OP_READ || op == OP_WRITE)
				accessed_copy[pick] = 1'b1;
			if (op == OP_WRITE)
				dirty_copy[pick] = 1'b1;
			a.slot = SLOT_W'(pick);
			a.last = 1'b1;
			answer_queue.push_back(a);
		end
	endfunction

	function automatic void flag_error(input string msg);
		if (err_cnt < 10)
			$display("[%0d] %s", cycle, msg);
		err_cnt++;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= OP_READ;
			for (int k = 0; k < SLOTS; k++) begin
				tag_copy[k] = '0;
				valid_copy[k] = 1'b0;
				dirty_copy[k] = 1'b0;
				accessed_copy[k] = 1'b0;
			end
			hand_copy = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_lookup(op_t'(s_axis_tuser), s_axis_tdata);
				sent_cnt <= sent_cnt + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (req_queue.size() > 0 && (quiet || $urandom_range(99) >= 23)) begin
					next_req = req_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_req.sector;
					s_axis_tuser <= next_req.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && sent_cnt >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(99) >= 23);
		end
	end

	// result monitor
	always @(posedge clk) begin
		cache_answer_t want;
		cache_answer_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.slot = m_axis_tdata[SLOT_W-1:0];
			got.hit = m_axis_tdata[SLOT_W];
			got.fill = m_axis_tdata[SLOT_W+1];
			got.wb = m_axis_tdata[SLOT_W+2];
			got.wb_sector = m_axis_tdata[SLOT_W+3 +: SECTOR_W];
			got.last = m_axis_tlast;
			rx_cnt <= rx_cnt + 1;
			if (answer_queue.size() == 0) begin
				flag_error($sformatf("unexpected transfer slot=%0d hit=%b fill=%b wb=%b sec=%h last=%b",
					got.slot, got.hit, got.fill, got.wb, got.wb_sector, got.last));
			end else begin
				want = answer_queue.pop_front();
				if (got !== want)
					flag_error($sformatf({"mismatch: exp slot=%0d hit=%b fill=%b wb=%b sec=%h last=%b",
						" / got slot=%0d hit=%b fill=%b wb=%b sec=%h last=%b"},
						want.slot, want.hit, want.fill, want.wb, want.wb_sector, want.last,
						got.slot, got.hit, got.fill, got.wb, got.wb_sector, got.last));
			end
		end
	end

	function automatic sector_req_t make_req(input op_t op, input logic [SECTOR_W-1:0] sector);
		sector_req_t r;
		r.op = op;
		r.sector = sector;
		return r;
	endfunction

	// stimulus and end of run
	initial begin
		int pick;
		op_t op;
		logic [SECTOR_W-1:0] sec;
		sector_pool[0] = '0;
		sector_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			sector_pool[i] = $urandom;

		// directed: empty flush, hits, misses, marks kept across flushes
		req_queue.push_back(make_req(OP_FLUSH, 32'h0000_0000));
		req_queue.push_back(make_req(OP_READ, 32'h0000_0000));
		req_queue.push_back(make_req(OP_READ, 32'h0000_0000));
		req_queue.push_back(make_req(OP_WRITE, 32'hFFFF_FFFF));
		req_queue.push_back(make_req(OP_WRITE, 32'hFFFF_FFFF));
		req_queue.push_back(make_req(OP_READ_AHEAD, 32'h8000_0000));
		req_queue.push_back(make_req(OP_READ_AHEAD, 32'h8000_0000));
		req_queue.push_back(make_req(OP_READ, 32'h0000_0001));
		req_queue.push_back(make_req(OP_WRITE, 32'h0000_0000));
		req_queue.push_back(make_req(OP_FLUSH, 32'hFFFF_FFFF));
		req_queue.push_back(make_req(OP_FLUSH, 32'h1234_5678));
		req_queue.push_back(make_req(OP_READ_AHEAD, 32'h7FFF_FFFF));
		req_queue.push_back(make_req(OP_WRITE, 32'h5555_5555));
		req_queue.push_back(make_req(OP_WRITE, 32'hAAAA_AAAA));
		req_queue.push_back(make_req(OP_READ, 32'h7FFF_FFFF));
		req_queue.push_back(make_req(OP_FLUSH, 32'h0000_0000));

		// reset
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_RANDOM; i++) begin
			// sender pauses until the cache has answered everything
			if (i == 0 || i == N_RANDOM / 2) begin
				while (req_queue.size() != 0 || s_axis_tvalid || answer_queue.size() != 0)
					@(negedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 34)
				op = OP_READ;
			else if (pick < 64)
				op = OP_WRITE;
			else if (pick < 93)
				op = OP_READ_AHEAD;
			else
				op = OP_FLUSH;
			// mostly a working set a bit larger than the cache, some fresh sectors
			if ($urandom_range(9) == 0)
				sec = $urandom;
			else
				sec = sector_pool[$urandom_range(POOL - 1)];
			req_queue.push_back(make_req(op, sec));
		end

		// drain
		while (req_queue.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (answer_queue.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);
		if (answer_queue.size() != 0)
			flag_error($sformatf("%0d answers never arrived", answer_queue.size()));

		$display("requests %0d, answers %0d, hits %0d, evictions %0d (%0d dirty)",
			sent_cnt, rx_cnt, hit_cnt, evict_cnt, evict_wb_cnt);
		$display("flushes %0d writing back %0d slots, errors %0d, cycles %0d",
			flush_cnt, flush_wb_cnt, err_cnt, cycle);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
